// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: src/lzx_med_pkg.sv
`timescale 1ns / 1ps

package lzx_med_pkg;

    localparam int SYM_W   = 12;
    localparam int LSYM_W  = 8;
    localparam int FOOT_W  = 17;
    localparam int ASYM_W  = 3;
    localparam int OFS_W   = 25;
    localparam int LEN_W   = 9;
    localparam int LIT_W   = 8;
    localparam int SLOT_W  = 9;
    localparam int FBITS_W = 5;
    localparam int EXTRA_W = FOOT_W + ASYM_W;
    localparam int HDR_W   = 3;

    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 48;

    localparam logic OP_DECODE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    localparam logic [SYM_W-1:0]   FIRST_MATCH_SYM = 12'd256;
    localparam logic [HDR_W-1:0]   HDR_LONG        = 3'd7;
    localparam logic [LEN_W-1:0]   LEN_MAX         = 9'd257;
    localparam logic [LEN_W-1:0]   LEN_LONG_BIAS   = 9'd9;
    localparam logic [LEN_W-1:0]   LEN_MIN         = 9'd2;
    localparam logic [OFS_W-1:0]   OFS_BIAS        = 25'd2;
    localparam logic [OFS_W-1:0]   OFS_RESET       = 25'd1;
    localparam logic [FBITS_W-1:0] ALIGN_BITS      = 5'd3;
    localparam logic [FBITS_W-1:0] FOOT_BITS_MAX   = 5'd17;

    typedef struct packed {
        logic [OFS_W-1:0]  load_third;
        logic [OFS_W-1:0]  load_second;
        logic [OFS_W-1:0]  load_first;
        logic [ASYM_W-1:0] aligned_symbol;
        logic [FOOT_W-1:0] footer_value;
        logic [LSYM_W-1:0] length_symbol;
        logic [SYM_W-1:0]  main_symbol;
    } in_item_t;

    localparam int ITEM_W = $bits(in_item_t);

    function automatic logic [FBITS_W-1:0] slot_foot_width(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] t;
        begin
            t = slot - 9'd2;
            priority if (slot < 9'd4)
            begin
                return '0;
            end
            else if (slot < 9'd36)
            begin
                return t[FBITS_W:1];
            end
            else
            begin
                return FOOT_BITS_MAX;
            end
        end
    endfunction

    function automatic logic [OFS_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] t;
        logic [4:0]        sh;
        begin
            t  = slot - 9'd34;
            sh = 5'(slot[SLOT_W-1:1]) - 5'd1;
            priority if (slot < 9'd4)
            begin
                return OFS_W'(slot);
            end
            else if (slot < 9'd38)
            begin
                return {{(OFS_W-2){1'b0}}, 1'b1, slot[0]} << sh;
            end
            else
            begin
                return {t[7:0], {FOOT_W{1'b0}}};
            end
        end
    endfunction

    function automatic logic [FOOT_W-1:0] low_mask(input logic [FBITS_W-1:0] bits);
        begin
            return ~({FOOT_W{1'b1}} << bits);
        end
    endfunction

endpackage

// File: src/lzx_match_element_decoder.sv
// Channel   Dir  Fields (lowest bit first)
// s_axis    in   tuser: opcode; tdata: main_symbol, length_symbol, footer_value,
//                aligned_symbol, load_first, load_second, load_third
// m_axis    out  tuser: is_literal; tdata: literal_byte, match_offset, match_length
// cfg       in   cfg_wr_data: aligned_mode, written when cfg_wr_en is high
//
// One request per cycle is accepted while the output is not stalled. A decode request
// passes the stage register, then its result is registered in the output register; load
// requests give no result. The recent-offset update is a mux and an add-subtract in
// the compute stage, which sets the single-cycle throughput. Reset sets the recent
// offsets to one and clears aligned_mode and all valid flags. A stalled output holds
// its result while the input stage keeps taking requests until the stage register is full.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lzx_match_element_decoder
    import lzx_med_pkg::*;
#(
    parameter int NUM_POSITION_SLOTS = 289
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_wr_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // main_symbol[11:0], length_symbol[19:12], footer_value[36:20],
    // aligned_symbol[39:37], load_first[64:40], load_second[89:65],
    // load_third[114:90], zero fill above
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // literal_byte[7:0], match_offset[32:8], match_length[41:33], zero fill above
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // is_literal
    output logic                 m_axis_tuser
);

    localparam logic [SLOT_W-1:0] SLOT_MAX = SLOT_W'(NUM_POSITION_SLOTS - 1);

    logic             aligned_mode_reg;
    logic             s1_valid_reg;
    logic             s1_op_reg;
    in_item_t         s1_item_reg;
    logic [OFS_W-1:0] recent_first_reg, recent_second_reg, recent_third_reg;
    logic [OFS_W-1:0] recent_first_next, recent_second_next, recent_third_next;
    logic             m_valid_reg;
    logic             m_lit_reg;
    logic [LIT_W-1:0] m_byte_reg;
    logic [OFS_W-1:0] m_ofs_reg;
    logic [LEN_W-1:0] m_len_reg;

    logic               advance;
    logic               s1_fire;
    logic               is_lit;
    logic [SYM_W-1:0]   code;
    logic [SLOT_W-1:0]  slot_raw, slot;
    logic [HDR_W-1:0]   header;
    logic [LEN_W-1:0]   long_len, length;
    logic [FBITS_W-1:0] fbits;
    logic [FOOT_W-1:0]  foot_masked;
    logic [EXTRA_W-1:0] extra;
    logic [OFS_W-1:0]   new_ofs, offset;
    logic [LIT_W-1:0]   lit_byte;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s1_fire       = s1_valid_reg && advance;
    assign s_axis_tready = !s1_valid_reg || advance;

    assign is_lit   = (s1_item_reg.main_symbol < FIRST_MATCH_SYM);
    assign lit_byte = s1_item_reg.main_symbol[LIT_W-1:0];
    assign code     = s1_item_reg.main_symbol - FIRST_MATCH_SYM;
    assign header   = code[HDR_W-1:0];
    assign slot_raw = code[SYM_W-1:HDR_W];
    assign slot     = (slot_raw > SLOT_MAX) ? SLOT_MAX : slot_raw;

    assign long_len = LEN_W'(s1_item_reg.length_symbol) + LEN_LONG_BIAS;

    always_comb
    begin
        if (header == HDR_LONG)
        begin
            length = (long_len > LEN_MAX) ? LEN_MAX : long_len;
        end
        else
        begin
            length = LEN_W'(header) + LEN_MIN;
        end
    end

    assign fbits = slot_foot_width(slot);

    always_comb
    begin
        if (aligned_mode_reg && (fbits >= ALIGN_BITS))
        begin
            foot_masked = s1_item_reg.footer_value & low_mask(fbits - ALIGN_BITS);
            extra       = {foot_masked, s1_item_reg.aligned_symbol};
        end
        else
        begin
            foot_masked = s1_item_reg.footer_value & low_mask(fbits);
            extra       = EXTRA_W'(foot_masked);
        end
    end

    assign new_ofs = slot_base(slot) + OFS_W'(extra) - OFS_BIAS;

    always_comb
    begin
        recent_first_next  = recent_first_reg;
        recent_second_next = recent_second_reg;
        recent_third_next  = recent_third_reg;
        offset             = new_ofs;
        if (s1_op_reg == OP_LOAD)
        begin
            recent_first_next  = s1_item_reg.load_first;
            recent_second_next = s1_item_reg.load_second;
            recent_third_next  = s1_item_reg.load_third;
        end
        else if (!is_lit)
        begin
            priority if (slot == 9'd0)
            begin
                offset = recent_first_reg;
            end
            else if (slot == 9'd1)
            begin
                offset             = recent_second_reg;
                recent_second_next = recent_first_reg;
                recent_first_next  = recent_second_reg;
            end
            else if (slot == 9'd2)
            begin
                offset            = recent_third_reg;
                recent_third_next = recent_first_reg;
                recent_first_next = recent_third_reg;
            end
            else
            begin
                recent_third_next  = recent_second_reg;
                recent_second_next = recent_first_reg;
                recent_first_next  = new_ofs;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aligned_mode_reg  <= 1'b0;
            s1_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            recent_first_reg  <= OFS_RESET;
            recent_second_reg <= OFS_RESET;
            recent_third_reg  <= OFS_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                aligned_mode_reg <= cfg_wr_data;
            end
            if (s_axis_tready)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                m_valid_reg <= s1_valid_reg && (s1_op_reg == OP_DECODE);
            end
            if (s1_fire)
            begin
                recent_first_reg  <= recent_first_next;
                recent_second_reg <= recent_second_next;
                recent_third_reg  <= recent_third_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            s1_op_reg   <= s_axis_tuser;
            s1_item_reg <= in_item_t'(s_axis_tdata[ITEM_W-1:0]);
        end
        if (s1_fire)
        begin
            m_lit_reg  <= is_lit;
            m_byte_reg <= is_lit ? lit_byte : '0;
            m_ofs_reg  <= is_lit ? '0 : offset;
            m_len_reg  <= is_lit ? '0 : length;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_lit_reg;
    assign m_axis_tdata  = M_TDATA_W'({m_len_reg, m_ofs_reg, m_byte_reg});

    `ASSERT_IMPLY(a_lit_clean, m_valid_reg && m_lit_reg,
        (m_ofs_reg == '0) && (m_len_reg == '0), "literal result carries match fields")
    `ASSERT_IMPLY(a_match_len, m_valid_reg && !m_lit_reg,
        (m_len_reg >= LEN_MIN) && (m_len_reg <= LEN_MAX) && (m_byte_reg == '0),
        "match result out of range")
    `ASSERT_NEXT(a_load_sets, s1_fire && (s1_op_reg == OP_LOAD),
        (recent_first_reg == $past(s1_item_reg.load_first))
            && (recent_third_reg == $past(s1_item_reg.load_third)),
        "load did not set recent offsets")
    `ASSERT_NEXT(a_load_silent, advance && s1_valid_reg && (s1_op_reg == OP_LOAD),
        !m_valid_reg, "load produced a result")
    `ASSERT_NEXT(a_rep0_keeps,
        s1_fire && (s1_op_reg == OP_DECODE) && !is_lit && (slot == 9'd0),
        $stable(recent_first_reg) && $stable(recent_second_reg)
            && $stable(recent_third_reg),
        "repeat of first offset changed the queue")

endmodule
